### design/dnp_pkg.sv
package dnp_pkg;

  // Defaults for the top-level parameters and the queue depth
  localparam int VALUE_BITS_DEF  = 48;
  localparam int FRAC_DIGITS_DEF = 3;
  localparam int QUEUE_DEPTH     = 2;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int MAXD_W     = 4;
  localparam int LIMIT_W    = 47;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;

  localparam logic [MAXD_W-1:0] MAX_DIGITS_RST = 4'd10;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DIGITS = 2'd0,
    CFG_MAX_VALUE  = 2'd1,
    CFG_FRAC_MODE  = 2'd2
  } cfg_index_t;

  // Character codes the parser reacts to
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Configuration seen by the front and the back
  typedef struct packed {
    logic [MAXD_W-1:0]  max_digits;
    logic [LIMIT_W-1:0] max_value;
    logic               frac_mode;
  } cfg_t;

  // Power of ten, for elaboration-time constants
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

### design/dnp_front.sv
module dnp_front #(
  parameter int VALUE_BITS  = dnp_pkg::VALUE_BITS_DEF,
  parameter int FRAC_DIGITS = dnp_pkg::FRAC_DIGITS_DEF,
  localparam int MAG_W   = VALUE_BITS - 1,
  localparam int FRAC_W  = $clog2(dnp_pkg::pow10(FRAC_DIGITS)),
  localparam int ENTRY_W = MAG_W + FRAC_W + 2 + dnp_pkg::CHAR_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dnp_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dnp_pkg::CHAR_W-1:0]  ch,
  output logic                        push,
  output logic [ENTRY_W-1:0]          push_data,
  input  logic                        full
);
  import dnp_pkg::*;

  localparam int PROD_W = MAG_W + 4;
  localparam int CNT_W  = MAXD_W + 1;
  localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);

  typedef enum logic [2:0] {PH_IDLE, PH_MINUS, PH_PLUS, PH_INT, PH_FRAC} phase_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
    logic              err;
    logic              neg;
    logic [CHAR_W-1:0] stop;
  } entry_t;

  // Weight of the next fraction digit: 10^(FRAC_DIGITS-1-n)
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [FCNT_W-1:0] n);
    logic [FRAC_W-1:0] w;
    w = FRAC_W'(1);
    for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
      if (i + int'(n) < FRAC_DIGITS - 1) w = FRAC_W'(w * 10);
    end
    return w;
  endfunction

  phase_t            phase, phase_next;
  logic [MAG_W-1:0]  mag, mag_next;
  logic [CNT_W-1:0]  dcnt, dcnt_next;
  logic              neg, neg_next;
  logic [FRAC_W-1:0] frac, frac_next;
  logic [FCNT_W-1:0] fcnt, fcnt_next;

  logic              accept;
  logic              is_digit;
  logic [3:0]        d;
  logic [PROD_W-1:0] prod;
  logic              sat;
  logic [CNT_W-1:0]  dcnt_inc;
  logic              over_cnt;
  logic [FRAC_W-1:0] frac_add;
  logic              emit;
  entry_t            ent;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Classify the character and prepare the digit updates
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign d        = is_digit ? ch[3:0] : 4'd0;
  assign prod     = (PROD_W'(mag) << 3) + (PROD_W'(mag) << 1) + PROD_W'(d);
  assign sat      = |prod[PROD_W-1:MAG_W];
  assign dcnt_inc = dcnt + 1'b1;
  assign over_cnt = dcnt_inc > {1'b0, cfg.max_digits};
  assign frac_add = frac + FRAC_W'(frac_weight(fcnt) * d);

  // Next state and the word for the queue
  always_comb begin
    phase_next = phase;
    mag_next   = mag;
    dcnt_next  = dcnt;
    neg_next   = neg;
    frac_next  = frac;
    fcnt_next  = fcnt;
    emit       = 1'b0;
    ent.mag    = mag;
    ent.frac   = '0;
    ent.err    = 1'b0;
    ent.neg    = neg;
    ent.stop   = ch;
    if (accept) begin
      unique case (phase)
        PH_FRAC: begin
          if (is_digit) begin
            if (fcnt < FCNT_W'(FRAC_DIGITS)) begin
              frac_next = frac_add;
              fcnt_next = FCNT_W'(fcnt + 1'b1);
            end
          end else begin
            emit     = 1'b1;
            ent.frac = frac;
          end
        end
        default: begin
          if (is_digit) begin
            if (sat) begin
              emit     = 1'b1;
              ent.mag  = '1;
              ent.err  = 1'b1;
              ent.stop = '0;
            end else begin
              mag_next   = prod[MAG_W-1:0];
              phase_next = PH_INT;
              dcnt_next  = dcnt_inc;
              if (over_cnt) begin
                emit     = 1'b1;
                ent.mag  = prod[MAG_W-1:0];
                ent.err  = 1'b1;
                ent.stop = '0;
              end
            end
          end else if (ch == CH_POINT && cfg.frac_mode) begin
            phase_next = PH_FRAC;
            frac_next  = '0;
            fcnt_next  = '0;
          end else if (phase == PH_IDLE && ch == CH_SPACE) begin
            phase_next = PH_IDLE;
          end else if (phase == PH_IDLE && ch == CH_MINUS) begin
            neg_next   = 1'b1;
            phase_next = PH_MINUS;
          end else if ((phase == PH_IDLE || phase == PH_MINUS) && ch == CH_PLUS) begin
            phase_next = PH_PLUS;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
      // Drop the finished number
      if (emit) begin
        phase_next = PH_IDLE;
        mag_next   = '0;
        dcnt_next  = '0;
        neg_next   = 1'b0;
        frac_next  = '0;
        fcnt_next  = '0;
      end
    end
  end

  assign push      = emit;
  assign push_data = ent;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      mag   <= '0;
      dcnt  <= '0;
      neg   <= 1'b0;
      frac  <= '0;
      fcnt  <= '0;
    end else begin
      phase <= phase_next;
      mag   <= mag_next;
      dcnt  <= dcnt_next;
      neg   <= neg_next;
      frac  <= frac_next;
      fcnt  <= fcnt_next;
    end
  end

  a_fcnt_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt <= FCNT_W'(FRAC_DIGITS))
    else $error("fraction digit count beyond limit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (phase == PH_IDLE && mag == '0 && !neg && dcnt == '0))
    else $error("number state not cleared after a result");

endmodule

### design/dnp_queue.sv
module dnp_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = dnp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);
  import dnp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr + 1'b1);
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr + 1'b1);
      case ({push, pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(DEPTH)) && (!pop || pop_valid))
    else $error("queue count out of range or pop from empty");

endmodule

### design/dnp_back.sv
module dnp_back #(
  parameter int VALUE_BITS  = dnp_pkg::VALUE_BITS_DEF,
  parameter int FRAC_DIGITS = dnp_pkg::FRAC_DIGITS_DEF,
  localparam int MAG_W   = VALUE_BITS - 1,
  localparam int FRAC_W  = $clog2(dnp_pkg::pow10(FRAC_DIGITS)),
  localparam int ENTRY_W = MAG_W + FRAC_W + 2 + dnp_pkg::CHAR_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dnp_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  logic [ENTRY_W-1:0]            q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_BITS-1:0]  value,
  output logic                          range_error,
  output logic [dnp_pkg::CHAR_W-1:0]    stop_char
);
  import dnp_pkg::*;

  localparam longint SCALE   = pow10(FRAC_DIGITS);
  localparam int     SCALE_W = $clog2(SCALE + 1);
  localparam int     SUM_W   = MAG_W + SCALE_W;
  localparam int     CMP_W   = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
    logic              err;
    logic              neg;
    logic [CHAR_W-1:0] stop;
  } entry_t;

  entry_t            q;
  logic              a_valid;
  logic              a_ready, b_ready;
  logic [SUM_W-1:0]  a_sum;
  logic              a_err, a_neg;
  logic [CHAR_W-1:0] a_stop;

  logic              lim_err;
  logic [SUM_W-1:0]  scaled;
  logic              over;
  logic [MAG_W-1:0]  mag_fin;
  logic [VALUE_BITS-1:0] mag_ext;

  assign q       = q_data;
  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign q_pop   = q_valid && a_ready;

  // Stage A: limit check and scaling
  assign lim_err = (cfg.max_value != '0) && (CMP_W'(q.mag) > CMP_W'(cfg.max_value));
  assign scaled  = SUM_W'(q.mag) * SUM_W'(SCALE) + SUM_W'(q.frac);

  // Stage B: saturate and apply the sign
  assign over    = a_sum > SUM_W'({MAG_W{1'b1}});
  assign mag_fin = over ? '1 : a_sum[MAG_W-1:0];
  assign mag_ext = {1'b0, mag_fin};

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid   <= q_valid;
      if (b_ready) out_valid <= a_valid;
    end
  end

  // Load stage payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_sum  <= cfg.frac_mode ? scaled : SUM_W'(q.mag);
      a_err  <= q.err || lim_err;
      a_neg  <= q.neg;
      a_stop <= q.stop;
    end
    if (b_ready && a_valid) begin
      value       <= a_neg ? -mag_ext : mag_ext;
      range_error <= a_err || over;
      stop_char   <= a_stop;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_ready) |=> (a_valid && $stable(a_sum) && $stable(a_stop)))
    else $error("stage A lost its word while the output stalled");

endmodule

### design/decimal_number_parser_unit.sv
// Streaming ASCII decimal parser. One character is taken per cycle on the ch channel
// while the queue is not full; leading spaces are skipped, an optional '-' and then an
// optional '+' are taken, and digits build up a magnitude. The first character that
// does not continue the number ends it and comes back as stop_char with the signed
// value and range_error; a digit that pushes the count past max_digits (or the
// magnitude past its range) ends the number at once with range_error set and stop_char
// zero. With frac_mode set, value is in units of 10^-FRAC_DIGITS and a '.' starts a
// fraction. The sustained rate is one character per cycle while the queue is not full,
// set by the per-character multiply-by-ten and add in the front parser; a result passes
// through the queue, the scaling stage, then the sign and output register before it is
// presented at the output. A two-word queue lets the parser keep taking characters
// while results wait at the output. Configuration writes are taken in every cycle.
module decimal_number_parser_unit #(
  parameter int VALUE_BITS  = dnp_pkg::VALUE_BITS_DEF,
  parameter int FRAC_DIGITS = dnp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dnp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dnp_pkg::CHAR_W-1:0]     ch,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [VALUE_BITS-1:0]   value,
  output logic                           range_error,
  output logic [dnp_pkg::CHAR_W-1:0]     stop_char
);
  import dnp_pkg::*;

  localparam int MAG_W   = VALUE_BITS - 1;
  localparam int FRAC_W  = $clog2(pow10(FRAC_DIGITS));
  localparam int ENTRY_W = MAG_W + FRAC_W + 2 + CHAR_W;

  cfg_t               cfg;
  logic               push, full;
  logic [ENTRY_W-1:0] push_data;
  logic               q_pop, q_valid;
  logic [ENTRY_W-1:0] q_data;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_digits <= MAX_DIGITS_RST;
      cfg.max_value  <= '0;
      cfg.frac_mode  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_DIGITS: cfg.max_digits <= cfg_data[MAXD_W-1:0];
        CFG_MAX_VALUE:  cfg.max_value  <= cfg_data[LIMIT_W-1:0];
        CFG_FRAC_MODE:  cfg.frac_mode  <= cfg_data[0];
        default:        cfg            <= cfg;
      endcase
    end
  end

  dnp_front #(
    .VALUE_BITS  (VALUE_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  dnp_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  dnp_back #(
    .VALUE_BITS  (VALUE_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .range_error (range_error),
    .stop_char   (stop_char)
  );

endmodule
